### src/apu_pkg.sv
package apu_pkg;

  localparam int unsigned FRAME_PERIOD = 8192;
  localparam int unsigned FRAME_W      = $clog2(FRAME_PERIOD + 1);

  localparam int unsigned MIR_DEPTH = 48;
  localparam int unsigned MIR_AW    = 6;
  localparam int unsigned CD_W      = 22;
  localparam int unsigned CPS_W     = 12;
  localparam logic [CPS_W-1:0] CPS_RESET = 12'd95;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  localparam logic [5:0] REG_NR10 = 6'h10;
  localparam logic [5:0] REG_NR11 = 6'h11;
  localparam logic [5:0] REG_NR12 = 6'h12;
  localparam logic [5:0] REG_NR13 = 6'h13;
  localparam logic [5:0] REG_NR14 = 6'h14;
  localparam logic [5:0] REG_NR21 = 6'h16;
  localparam logic [5:0] REG_NR22 = 6'h17;
  localparam logic [5:0] REG_NR23 = 6'h18;
  localparam logic [5:0] REG_NR24 = 6'h19;
  localparam logic [5:0] REG_NR30 = 6'h1A;
  localparam logic [5:0] REG_NR31 = 6'h1B;
  localparam logic [5:0] REG_NR32 = 6'h1C;
  localparam logic [5:0] REG_NR33 = 6'h1D;
  localparam logic [5:0] REG_NR34 = 6'h1E;
  localparam logic [5:0] REG_NR41 = 6'h20;
  localparam logic [5:0] REG_NR42 = 6'h21;
  localparam logic [5:0] REG_NR43 = 6'h22;
  localparam logic [5:0] REG_NR44 = 6'h23;
  localparam logic [5:0] REG_NR50 = 6'h24;
  localparam logic [5:0] REG_NR51 = 6'h25;
  localparam logic [5:0] REG_NR52 = 6'h26;
  localparam logic [5:0] REG_WAVE = 6'h30;

  localparam logic [7:0] DUTY_TABLE [4] = '{8'h01, 8'h03, 8'h0F, 8'hFC};

  typedef struct packed {
    logic              we;
    logic [MIR_AW-1:0] idx;
    logic [7:0]        data;
  } mir_wr_t;

  typedef struct packed {
    logic        vld;
    logic        kind;
    logic [15:0] left;
    logic [15:0] right;
    logic [7:0]  data;
  } res_t;

  typedef struct packed {
    logic [3:0]      act;
    logic [3:0][3:0] loud;
    logic [1:0]      sq_bit;
    logic [3:0]      wave_val;
    logic            nz_bit;
    logic [7:0]      pan;
    logic [2:0]      mvl;
    logic [2:0]      mvr;
  } mix_in_t;

endpackage

### src/apu_mirror.sv
module apu_mirror import apu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mir_wr_t           wr_i,
  input  logic              rd_en_i,
  input  logic [MIR_AW-1:0] rd_idx_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0] mem [MIR_DEPTH];
  logic [MIR_DEPTH-1:0] vld_q;
  logic [7:0] rd_q;
  logic rd_ok;

  assign rd_ok = rd_idx_i < MIR_AW'(MIR_DEPTH);

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.idx] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.we) begin
      vld_q[wr_i.idx] <= 1'b1;
    end
  end

  // write-through so a read right behind a write sees the new byte
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.we && wr_i.idx == rd_idx_i) begin
        rd_q <= wr_i.data;
      end else if (rd_ok && vld_q[rd_idx_i]) begin
        rd_q <= mem[rd_idx_i];
      end else begin
        rd_q <= '0;
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

### src/apu_mix.sv
module apu_mix import apu_pkg::*; (
  input  mix_in_t     mix_i,
  output logic [15:0] left_o,
  output logic [15:0] right_o
);

  logic signed [5:0]  s [4];
  logic signed [7:0]  sum_l, sum_r;
  logic        [8:0]  gain_l, gain_r;
  logic signed [16:0] prod_l, prod_r;

  always_comb begin
    s[0] = mix_i.sq_bit[0] ? 6'(mix_i.loud[0]) : -6'(mix_i.loud[0]);
    s[1] = mix_i.sq_bit[1] ? 6'(mix_i.loud[1]) : -6'(mix_i.loud[1]);
    s[2] = 6'(mix_i.wave_val);
    s[3] = mix_i.nz_bit ? -6'(mix_i.loud[3]) : 6'(mix_i.loud[3]);
    sum_l = '0;
    sum_r = '0;
    for (int c = 0; c < 4; c++) begin
      if (mix_i.act[c] && mix_i.pan[4+c]) sum_l = sum_l + 8'(s[c]);
      if (mix_i.act[c] && mix_i.pan[c])   sum_r = sum_r + 8'(s[c]);
    end
    gain_l = {4'(mix_i.mvl) + 4'd1, 5'b0};
    gain_r = {4'(mix_i.mvr) + 4'd1, 5'b0};
    prod_l = 17'(sum_l) * signed'({8'b0, gain_l});
    prod_r = 17'(sum_r) * signed'({8'b0, gain_r});
  end

  // |sum| <= 60 and gain <= 256, so the product always fits 16 bits
  assign left_o  = prod_l[15:0];
  assign right_o = prod_r[15:0];

endmodule

### src/apu_core.sv
module apu_core import apu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [1:0]       op_i,
  input  logic [5:0]       off_i,
  input  logic [7:0]       data_i,
  input  logic [7:0]       mir_data_i,
  input  logic [CPS_W-1:0] cps_i,
  output mir_wr_t          mir_wr_o,
  output res_t             res_o
);

  logic [FRAME_W-1:0] frame_cnt_q, frame_cnt_d, fc_inc;
  logic [2:0]  fstep_q, fstep_d;
  logic [CPS_W-1:0] smp_cnt_q, smp_cnt_d;
  logic [CPS_W:0] smp_inc;
  logic        master_on_q, master_on_d;
  logic [2:0]  mvl_q, mvl_d, mvr_q, mvr_d;
  logic [7:0]  pan_q, pan_d;
  logic [3:0]  on_q, on_d;
  logic [3:0]  len_en_q, len_en_d;
  logic [10:0] per_q [3];
  logic [10:0] per_d [3];
  logic [CD_W-1:0] cd_q [4];
  logic [CD_W-1:0] cd_d [4];
  logic [8:0]  len_q [4];
  logic [8:0]  len_d [4];
  logic [3:0]  loud_q [4];
  logic [3:0]  loud_d [4];
  logic        env_inc_q [3];
  logic        env_inc_d [3];
  logic [2:0]  env_per_q [3];
  logic [2:0]  env_per_d [3];
  logic [2:0]  env_tmr_q [3];
  logic [2:0]  env_tmr_d [3];
  logic [3:0]  env_hi_q [3];
  logic [3:0]  env_hi_d [3];
  logic [1:0]  duty_q [2];
  logic [1:0]  duty_d [2];
  logic [2:0]  dpos_q [2];
  logic [2:0]  dpos_d [2];
  logic [2:0]  sw_per_q, sw_per_d, sw_shift_q, sw_shift_d;
  logic        sw_neg_q, sw_neg_d;
  logic [3:0]  sw_tmr_q, sw_tmr_d;
  logic [10:0] sw_shadow_q, sw_shadow_d;
  logic        wv_dac_q, wv_dac_d;
  logic [4:0]  wv_pos_q, wv_pos_d;
  logic [7:0]  wram_q [16];
  logic [7:0]  wram_d [16];
  logic [14:0] nz_lfsr_q, nz_lfsr_d;
  logic [3:0]  nz_shift_q, nz_shift_d;
  logic        nz_wid_q, nz_wid_d;
  logic [2:0]  nz_div_q, nz_div_d;

  logic [10:0] delta;
  logic [11:0] nf;
  logic        fb;
  logic [7:0]  wbyte;
  logic [3:0]  nib;
  logic [1:0]  wcode;
  logic [1:0]  ec;
  mix_in_t     mix;
  logic [15:0] mix_l, mix_r;

  function automatic logic [CD_W-1:0] nz_reload(logic [2:0] div, logic [3:0] sh);
    logic [6:0] base;
    base = (div == 3'd0) ? 7'd8 : {div, 4'b0};
    return CD_W'(base) << sh;
  endfunction

  function automatic logic [CD_W-1:0] sq_reload(logic [10:0] per);
    return CD_W'({12'h800 - {1'b0, per}, 2'b0});
  endfunction

  function automatic logic [CD_W-1:0] wv_reload(logic [10:0] per);
    return CD_W'({12'h800 - {1'b0, per}, 1'b0});
  endfunction

  always_comb begin
    frame_cnt_d = frame_cnt_q;
    fstep_d     = fstep_q;
    smp_cnt_d   = smp_cnt_q;
    master_on_d = master_on_q;
    mvl_d = mvl_q;
    mvr_d = mvr_q;
    pan_d = pan_q;
    on_d  = on_q;
    len_en_d = len_en_q;
    per_d = per_q;
    cd_d  = cd_q;
    len_d = len_q;
    loud_d = loud_q;
    env_inc_d = env_inc_q;
    env_per_d = env_per_q;
    env_tmr_d = env_tmr_q;
    env_hi_d  = env_hi_q;
    duty_d = duty_q;
    dpos_d = dpos_q;
    sw_per_d = sw_per_q;
    sw_shift_d = sw_shift_q;
    sw_neg_d = sw_neg_q;
    sw_tmr_d = sw_tmr_q;
    sw_shadow_d = sw_shadow_q;
    wv_dac_d = wv_dac_q;
    wv_pos_d = wv_pos_q;
    wram_d = wram_q;
    nz_lfsr_d = nz_lfsr_q;
    nz_shift_d = nz_shift_q;
    nz_wid_d = nz_wid_q;
    nz_div_d = nz_div_q;
    fc_inc  = frame_cnt_q + 1'b1;
    smp_inc = {1'b0, smp_cnt_q} + 1'b1;
    delta = '0;
    nf = '0;
    fb = 1'b0;
    ec = '0;
    mir_wr_o = '0;
    res_o = '0;

    if (fire_i) begin
      case (opcode_e'(op_i))
        OP_WRITE: begin
          if (off_i >= REG_NR10) begin
            mir_wr_o.we   = 1'b1;
            mir_wr_o.idx  = off_i - REG_NR10;
            mir_wr_o.data = data_i;
          end
          if (off_i >= REG_WAVE) begin
            wram_d[off_i[3:0]] = data_i;
          end
          case (off_i)
            REG_NR10: begin
              sw_per_d   = data_i[6:4];
              sw_neg_d   = data_i[3];
              sw_shift_d = data_i[2:0];
            end
            REG_NR11: begin
              duty_d[0] = data_i[7:6];
              len_d[0]  = 9'd64 - 9'(data_i[5:0]);
            end
            REG_NR21: begin
              duty_d[1] = data_i[7:6];
              len_d[1]  = 9'd64 - 9'(data_i[5:0]);
            end
            REG_NR12, REG_NR22, REG_NR42: begin
              ec = (off_i == REG_NR12) ? 2'd0 : (off_i == REG_NR22) ? 2'd1 : 2'd2;
              loud_d[(ec == 2'd2) ? 3 : ec] = data_i[7:4];
              env_hi_d[ec]  = data_i[7:4];
              env_inc_d[ec] = data_i[3];
              env_per_d[ec] = data_i[2:0];
              env_tmr_d[ec] = data_i[2:0];
              if (data_i[7:3] == 5'd0) on_d[(ec == 2'd2) ? 3 : ec] = 1'b0;
            end
            REG_NR13: per_d[0] = {per_q[0][10:8], data_i};
            REG_NR23: per_d[1] = {per_q[1][10:8], data_i};
            REG_NR33: per_d[2] = {per_q[2][10:8], data_i};
            REG_NR14: begin
              len_en_d[0] = data_i[6];
              per_d[0] = {data_i[2:0], per_q[0][7:0]};
              if (data_i[7]) begin
                on_d[0] = 1'b1;
                if (len_q[0] == 9'd0) len_d[0] = 9'd64;
                cd_d[0] = sq_reload(per_d[0]);
                env_tmr_d[0] = env_per_q[0];
                loud_d[0] = env_hi_q[0];
                sw_shadow_d = per_d[0];
                sw_tmr_d = (sw_per_q != 3'd0) ? 4'(sw_per_q) : 4'd8;
              end
            end
            REG_NR24: begin
              len_en_d[1] = data_i[6];
              per_d[1] = {data_i[2:0], per_q[1][7:0]};
              if (data_i[7]) begin
                on_d[1] = 1'b1;
                if (len_q[1] == 9'd0) len_d[1] = 9'd64;
                cd_d[1] = sq_reload(per_d[1]);
                env_tmr_d[1] = env_per_q[1];
                loud_d[1] = env_hi_q[1];
              end
            end
            REG_NR30: begin
              wv_dac_d = data_i[7];
              if (!data_i[7]) on_d[2] = 1'b0;
            end
            REG_NR31: len_d[2] = 9'd256 - 9'(data_i);
            REG_NR32: loud_d[2] = 4'(data_i[6:5]);
            REG_NR34: begin
              len_en_d[2] = data_i[6];
              per_d[2] = {data_i[2:0], per_q[2][7:0]};
              if (data_i[7]) begin
                on_d[2] = 1'b1;
                if (len_q[2] == 9'd0) len_d[2] = 9'd256;
                cd_d[2] = wv_reload(per_d[2]);
                wv_pos_d = '0;
              end
            end
            REG_NR41: len_d[3] = 9'd64 - 9'(data_i[5:0]);
            REG_NR43: begin
              nz_shift_d = data_i[7:4];
              nz_wid_d   = data_i[3];
              nz_div_d   = data_i[2:0];
            end
            REG_NR44: begin
              len_en_d[3] = data_i[6];
              if (data_i[7]) begin
                on_d[3] = 1'b1;
                if (len_q[3] == 9'd0) len_d[3] = 9'd64;
                cd_d[3] = nz_reload(nz_div_q, nz_shift_q);
                env_tmr_d[2] = env_per_q[2];
                loud_d[3] = env_hi_q[2];
                nz_lfsr_d = 15'h7FFF;
              end
            end
            REG_NR50: begin
              mvl_d = data_i[6:4];
              mvr_d = data_i[2:0];
            end
            REG_NR51: pan_d = data_i;
            REG_NR52: begin
              master_on_d = data_i[7];
              if (!data_i[7]) on_d = '0;
            end
            default: ;
          endcase
        end
        OP_READ: begin
          res_o.vld  = 1'b1;
          res_o.kind = 1'b1;
          if (off_i == REG_NR52) begin
            res_o.data = {master_on_q, 3'b111, on_q};
          end else if (off_i >= REG_NR10) begin
            res_o.data = mir_data_i;
          end
        end
        OP_TICK: begin
          if (master_on_q) begin
            // frame sequencer: length, sweep, envelope in that order
            if (fc_inc >= FRAME_W'(FRAME_PERIOD)) begin
              frame_cnt_d = '0;
              if (!fstep_q[0]) begin
                for (int c = 0; c < 4; c++) begin
                  if (len_q[c] != 9'd0 && len_en_q[c]) begin
                    len_d[c] = len_q[c] - 1'b1;
                    if (len_d[c] == 9'd0) on_d[c] = 1'b0;
                  end
                end
              end
              if ((fstep_q == 3'd2 || fstep_q == 3'd6) && sw_per_q != 3'd0) begin
                if (sw_tmr_q > 4'd1) begin
                  sw_tmr_d = sw_tmr_q - 1'b1;
                end else begin
                  sw_tmr_d = 4'(sw_per_q);
                  if (sw_shift_q != 3'd0) begin
                    delta = sw_shadow_q >> sw_shift_q;
                    nf = sw_neg_q ? {1'b0, sw_shadow_q} - {1'b0, delta}
                                  : {1'b0, sw_shadow_q} + {1'b0, delta};
                    if (nf[11]) begin
                      on_d[0] = 1'b0;
                    end else begin
                      per_d[0] = nf[10:0];
                      sw_shadow_d = nf[10:0];
                    end
                  end
                end
              end
              if (fstep_q == 3'd7) begin
                for (int e = 0; e < 3; e++) begin
                  if (env_per_q[e] != 3'd0) begin
                    if (env_tmr_q[e] > 3'd1) begin
                      env_tmr_d[e] = env_tmr_q[e] - 1'b1;
                    end else begin
                      env_tmr_d[e] = env_per_q[e];
                      if (env_inc_q[e] && loud_q[(e == 2) ? 3 : e] != 4'd15) begin
                        loud_d[(e == 2) ? 3 : e] = loud_q[(e == 2) ? 3 : e] + 1'b1;
                      end else if (!env_inc_q[e] && loud_q[(e == 2) ? 3 : e] != 4'd0) begin
                        loud_d[(e == 2) ? 3 : e] = loud_q[(e == 2) ? 3 : e] - 1'b1;
                      end
                    end
                  end
                end
              end
              fstep_d = fstep_q + 1'b1;
            end else begin
              frame_cnt_d = fc_inc;
            end

            for (int c = 0; c < 2; c++) begin
              if (on_d[c]) begin
                if (cd_q[c] <= CD_W'(1)) begin
                  cd_d[c] = sq_reload(per_d[c]);
                  dpos_d[c] = dpos_q[c] + 1'b1;
                end else begin
                  cd_d[c] = cd_q[c] - 1'b1;
                end
              end
            end
            if (on_d[2] && wv_dac_q) begin
              if (cd_q[2] <= CD_W'(1)) begin
                cd_d[2] = wv_reload(per_q[2]);
                wv_pos_d = wv_pos_q + 1'b1;
              end else begin
                cd_d[2] = cd_q[2] - 1'b1;
              end
            end
            if (on_d[3]) begin
              if (cd_q[3] <= CD_W'(1)) begin
                fb = nz_lfsr_q[0] ^ nz_lfsr_q[1];
                cd_d[3] = nz_reload(nz_div_q, nz_shift_q);
                nz_lfsr_d = {fb, nz_lfsr_q[14:1]};
                if (nz_wid_q) nz_lfsr_d[6] = fb;
              end else begin
                cd_d[3] = cd_q[3] - 1'b1;
              end
            end

            if (smp_inc >= {1'b0, cps_i}) begin
              smp_cnt_d   = '0;
              res_o.vld   = 1'b1;
              res_o.left  = mix_l;
              res_o.right = mix_r;
            end else begin
              smp_cnt_d = smp_inc[CPS_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    wbyte = wram_q[wv_pos_d[4:1]];
    nib   = wv_pos_d[0] ? wbyte[3:0] : wbyte[7:4];
    wcode = loud_d[2][1:0];
    mix.act       = {on_d[3], on_d[2] & wv_dac_q, on_d[1], on_d[0]};
    mix.loud      = {loud_d[3], loud_d[2], loud_d[1], loud_d[0]};
    mix.sq_bit[0] = DUTY_TABLE[duty_q[0]][dpos_d[0]];
    mix.sq_bit[1] = DUTY_TABLE[duty_q[1]][dpos_d[1]];
    mix.wave_val  = (wcode == 2'd0) ? 4'd0 : nib >> (wcode - 2'd1);
    mix.nz_bit    = nz_lfsr_d[0];
    mix.pan       = pan_q;
    mix.mvl       = mvl_q;
    mix.mvr       = mvr_q;
  end

  apu_mix u_mix (
    .mix_i  (mix),
    .left_o (mix_l),
    .right_o(mix_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cnt_q <= '0;
      fstep_q     <= '0;
      smp_cnt_q   <= '0;
      master_on_q <= 1'b1;
      mvl_q       <= 3'd7;
      mvr_q       <= 3'd7;
      pan_q       <= 8'hFF;
      on_q        <= '0;
      len_en_q    <= '0;
      per_q       <= '{default: '0};
      cd_q        <= '{default: '0};
      len_q       <= '{default: '0};
      loud_q      <= '{default: '0};
      env_inc_q   <= '{default: '0};
      env_per_q   <= '{default: '0};
      env_tmr_q   <= '{default: '0};
      env_hi_q    <= '{default: '0};
      duty_q      <= '{default: '0};
      dpos_q      <= '{default: '0};
      sw_per_q    <= '0;
      sw_shift_q  <= '0;
      sw_neg_q    <= 1'b0;
      sw_tmr_q    <= '0;
      sw_shadow_q <= '0;
      wv_dac_q    <= 1'b0;
      wv_pos_q    <= '0;
      wram_q      <= '{default: '0};
      nz_lfsr_q   <= 15'h7FFF;
      nz_shift_q  <= '0;
      nz_wid_q    <= 1'b0;
      nz_div_q    <= '0;
    end else begin
      frame_cnt_q <= frame_cnt_d;
      fstep_q     <= fstep_d;
      smp_cnt_q   <= smp_cnt_d;
      master_on_q <= master_on_d;
      mvl_q       <= mvl_d;
      mvr_q       <= mvr_d;
      pan_q       <= pan_d;
      on_q        <= on_d;
      len_en_q    <= len_en_d;
      per_q       <= per_d;
      cd_q        <= cd_d;
      len_q       <= len_d;
      loud_q      <= loud_d;
      env_inc_q   <= env_inc_d;
      env_per_q   <= env_per_d;
      env_tmr_q   <= env_tmr_d;
      env_hi_q    <= env_hi_d;
      duty_q      <= duty_d;
      dpos_q      <= dpos_d;
      sw_per_q    <= sw_per_d;
      sw_shift_q  <= sw_shift_d;
      sw_neg_q    <= sw_neg_d;
      sw_tmr_q    <= sw_tmr_d;
      sw_shadow_q <= sw_shadow_d;
      wv_dac_q    <= wv_dac_d;
      wv_pos_q    <= wv_pos_d;
      wram_q      <= wram_d;
      nz_lfsr_q   <= nz_lfsr_d;
      nz_shift_q  <= nz_shift_d;
      nz_wid_q    <= nz_wid_d;
      nz_div_q    <= nz_div_d;
    end
  end

endmodule

### src/four_channel_sound_generator.sv
// Four-channel sound unit (two squares, one with sweep, a 32-nibble wave channel and an
// LFSR noise channel) driven by one transaction per clock: opcode 0 advances the unit by
// one tick, 1 writes a sound register at reg_offset, 2 reads one back. A transaction is
// taken every cycle while the result register drains; it is registered, then processed in
// one pass through the channel state into the result register. Reads return the status
// byte at 0x26, else the last byte written (0 below 0x10). A stereo sample comes out once
// per sample period, counted in ticks (APB offset 0, reset 95).
module four_channel_sound_generator import apu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  reg_offset_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [15:0] left_sample_o,
  output logic [15:0] right_sample_o,
  output logic [7:0]  read_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             in_vld_q;
  logic [1:0]       op_q;
  logic [5:0]       off_q;
  logic [7:0]       dat_q;
  logic             out_vld_q;
  logic             kind_q;
  logic [15:0]      left_q, right_q;
  logic [7:0]       rdat_q;
  logic [CPS_W-1:0] cps_q;
  logic             fire, accept;
  logic [7:0]       mir_data;
  mir_wr_t          mir_wr;
  res_t             res;

  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;
  assign accept     = in_valid_i && in_ready_o;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(cps_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q <= CPS_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      cps_q <= pwdata[CPS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      off_q <= reg_offset_i;
      dat_q <= write_data_i;
    end
  end

  apu_mirror u_mirror (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (mir_wr),
    .rd_en_i  (accept),
    .rd_idx_i (reg_offset_i - REG_NR10),
    .rd_data_o(mir_data)
  );

  apu_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .op_i      (op_q),
    .off_i     (off_q),
    .data_i    (dat_q),
    .mir_data_i(mir_data),
    .cps_i     (cps_q),
    .mir_wr_o  (mir_wr),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q <= fire && res.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.vld) begin
      kind_q  <= res.kind;
      left_q  <= res.left;
      right_q <= res.right;
      rdat_q  <= res.data;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign result_kind_o  = kind_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;
  assign read_data_o    = rdat_q;

endmodule

### src/apu_checker.sv
module apu_checker import apu_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        result_kind_o,
  input logic [15:0] left_sample_o,
  input logic [15:0] right_sample_o,
  input logic [7:0]  read_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_read_no_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |-> left_sample_o == 16'd0 && right_sample_o == 16'd0)
    else $error("read transaction carries sample data");

  a_sample_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |-> read_data_o == 8'd0)
    else $error("sample transaction carries read data");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind four_channel_sound_generator apu_checker u_apu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .left_sample_o (left_sample_o),
  .right_sample_o(right_sample_o),
  .read_data_o   (read_data_o)
);

### verif/four_channel_sound_generator_test.sv
`timescale 1ns / 1ps

module four_channel_sound_generator_test;
  import apu_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] op;
    logic [5:0] off;
    logic [7:0] data;
  } bus_txn_t;

  typedef struct {
    logic        kind;
    logic [15:0] left;
    logic [15:0] right;
    logic [7:0]  data;
  } sound_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = '0;
  logic [5:0]  reg_offset_i = '0;
  logic [7:0]  write_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        result_kind_o;
  logic [15:0] left_sample_o;
  logic [15:0] right_sample_o;
  logic [7:0]  read_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  four_channel_sound_generator u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------- sound unit predictor ----------------
  int cps;
  logic [7:0] mir [48];
  int fcnt, fstep, scnt;
  bit mon;
  int mvl, mvr;
  logic [7:0] pan;
  bit con [4];
  logic [10:0] per [3];
  int unsigned cd [4];
  int len [4], loud [4];
  int env_inc [3], env_per [3], env_tim [3];
  int duty [2], dpos [2];
  int sw_per, sw_neg, sw_sh, sw_tim, sw_shadow;
  int wdac, wpos;
  int lfsr, nsh, nw, ndiv;

  sound_out_t expected_q [$];
  bus_txn_t   pending_q [$];
  int errors = 0, n_items = 0, n_samples = 0, n_reads = 0;

  function automatic logic [7:0] mirror_at(logic [5:0] off);
    return (off >= 6'h10) ? mir[off - 6'h10] : 8'h00;
  endfunction

  function automatic int unsigned noise_reload();
    int unsigned d;
    d = (ndiv == 0) ? 8 : ndiv * 16;
    return d << nsh;
  endfunction

  function automatic void clock_envelope(int e, int c);
    if (env_per[e] == 0) return;
    if (env_tim[e] > 1) begin
      env_tim[e]--;
      return;
    end
    env_tim[e] = env_per[e];
    if (env_inc[e] != 0 && loud[c] < 15) loud[c]++;
    else if (env_inc[e] == 0 && loud[c] > 0) loud[c]--;
  endfunction

  function automatic void clock_frame();
    logic [5:0] ctl [4];
    int unsigned delta, nf;
    ctl = '{6'h14, 6'h19, 6'h1E, 6'h23};
    if ((fstep & 1) == 0) begin
      for (int c = 0; c < 4; c++) begin
        if (len[c] > 0 && (mirror_at(ctl[c]) & 8'h40) != 8'h00) begin
          len[c]--;
          if (len[c] == 0) con[c] = 0;
        end
      end
    end
    if ((fstep == 2 || fstep == 6) && sw_per != 0) begin
      if (sw_tim > 1) sw_tim--;
      else begin
        sw_tim = sw_per;
        if (sw_sh > 0) begin
          delta = sw_shadow >> sw_sh;
          nf = sw_neg ? sw_shadow - delta : sw_shadow + delta;
          if (nf > 2047) con[0] = 0;
          else begin
            per[0] = nf[10:0];
            sw_shadow = nf;
          end
        end
      end
    end
    if (fstep == 7) begin
      clock_envelope(0, 0);
      clock_envelope(1, 1);
      clock_envelope(2, 3);
    end
    fstep = (fstep + 1) & 7;
  endfunction

  function automatic void clock_timers();
    int x;
    for (int c = 0; c < 2; c++) begin
      if (con[c]) begin
        if (cd[c] <= 1) begin
          cd[c] = (2048 - per[c]) * 4;
          dpos[c] = (dpos[c] + 1) & 7;
        end else cd[c]--;
      end
    end
    if (con[2] && wdac != 0) begin
      if (cd[2] <= 1) begin
        cd[2] = (2048 - per[2]) * 2;
        wpos = (wpos + 1) & 31;
      end else cd[2]--;
    end
    if (con[3]) begin
      if (cd[3] <= 1) begin
        x = (lfsr ^ (lfsr >> 1)) & 1;
        cd[3] = noise_reload();
        lfsr = ((lfsr >> 1) | (x << 14)) & 32'h7FFF;
        if (nw != 0) lfsr = (lfsr & ~(1 << 6)) | (x << 6);
      end else cd[3]--;
    end
  endfunction

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic sound_out_t mix_sample();
    sound_out_t o;
    int l, r, code;
    int s [4];
    bit act [4];
    logic [7:0] b;
    logic [3:0] n;
    l = 0;
    r = 0;
    s = '{0, 0, 0, 0};
    for (int c = 0; c < 2; c++) begin
      act[c] = con[c];
      if (act[c]) s[c] = DUTY_TABLE[duty[c]][dpos[c]] ? loud[c] : -loud[c];
    end
    act[2] = con[2] && wdac != 0;
    if (act[2]) begin
      b = mir[32 + (wpos >> 1)];
      n = wpos[0] ? b[3:0] : b[7:4];
      code = loud[2] & 3;
      s[2] = code != 0 ? int'(n >> (code - 1)) : 0;
    end
    act[3] = con[3];
    if (act[3]) s[3] = lfsr[0] ? -loud[3] : loud[3];
    for (int c = 0; c < 4; c++) begin
      if (act[c]) begin
        if (pan[4 + c]) l += s[c];
        if (pan[c]) r += s[c];
      end
    end
    l = sat16(l * ((mvl + 1) * 32));
    r = sat16(r * ((mvr + 1) * 32));
    o.kind = 1'b0;
    o.left = l[15:0];
    o.right = r[15:0];
    o.data = 8'h00;
    return o;
  endfunction

  function automatic void write_envelope(int e, int c, logic [7:0] v);
    loud[c] = v[7:4];
    env_inc[e] = v[3];
    env_per[e] = v[2:0];
    env_tim[e] = env_per[e];
    if (v[7:3] == 0) con[c] = 0;
  endfunction

  function automatic void trigger_square(int c, logic [5:0] env_reg, int e);
    con[c] = 1;
    if (len[c] == 0) len[c] = 64;
    cd[c] = (2048 - per[c]) * 4;
    env_tim[e] = env_per[e];
    loud[c] = mirror_at(env_reg) >> 4;
  endfunction

  function automatic void write_sound_reg(logic [5:0] off, logic [7:0] v);
    if (off < 6'h10) return;
    mir[off - 6'h10] = v;
    case (off)
      REG_NR10: begin
        sw_per = v[6:4];
        sw_neg = v[3];
        sw_sh = v[2:0];
      end
      REG_NR11: begin
        duty[0] = v[7:6];
        len[0] = 64 - v[5:0];
      end
      REG_NR21: begin
        duty[1] = v[7:6];
        len[1] = 64 - v[5:0];
      end
      REG_NR12: write_envelope(0, 0, v);
      REG_NR22: write_envelope(1, 1, v);
      REG_NR42: write_envelope(2, 3, v);
      REG_NR13: per[0][7:0] = v;
      REG_NR23: per[1][7:0] = v;
      REG_NR33: per[2][7:0] = v;
      REG_NR14: begin
        per[0][10:8] = v[2:0];
        if (v[7]) begin
          trigger_square(0, REG_NR12, 0);
          sw_shadow = per[0];
          sw_tim = sw_per > 0 ? sw_per : 8;
        end
      end
      REG_NR24: begin
        per[1][10:8] = v[2:0];
        if (v[7]) trigger_square(1, REG_NR22, 1);
      end
      REG_NR30: begin
        wdac = v[7];
        if (wdac == 0) con[2] = 0;
      end
      REG_NR31: len[2] = 256 - v;
      REG_NR32: loud[2] = v[6:5];
      REG_NR34: begin
        per[2][10:8] = v[2:0];
        if (v[7]) begin
          con[2] = 1;
          if (len[2] == 0) len[2] = 256;
          cd[2] = (2048 - per[2]) * 2;
          wpos = 0;
        end
      end
      REG_NR41: len[3] = 64 - v[5:0];
      REG_NR43: begin
        nsh = v[7:4];
        nw = v[3];
        ndiv = v[2:0];
      end
      REG_NR44: begin
        if (v[7]) begin
          con[3] = 1;
          if (len[3] == 0) len[3] = 64;
          cd[3] = noise_reload();
          env_tim[2] = env_per[2];
          loud[3] = mirror_at(REG_NR42) >> 4;
          lfsr = 32'h7FFF;
        end
      end
      REG_NR50: begin
        mvl = v[6:4];
        mvr = v[2:0];
      end
      REG_NR51: pan = v;
      REG_NR52: begin
        mon = v[7];
        if (!mon) con = '{0, 0, 0, 0};
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_sound(bus_txn_t t);
    sound_out_t o;
    if (t.op == OP_WRITE) begin
      write_sound_reg(t.off, t.data);
      return;
    end
    if (t.op == OP_READ) begin
      o.kind = 1'b1;
      o.left = '0;
      o.right = '0;
      if (t.off == REG_NR52)
        o.data = {mon, 3'b111, con[3], con[2], con[1], con[0]};
      else o.data = mirror_at(t.off);
      expected_q.push_back(o);
      return;
    end
    if (t.op != OP_TICK || !mon) return;
    fcnt++;
    if (fcnt >= FRAME_PERIOD) begin
      fcnt = 0;
      clock_frame();
    end
    clock_timers();
    scnt++;
    if (scnt >= cps) begin
      scnt = 0;
      expected_q.push_back(mix_sample());
    end
  endfunction

  function automatic void reset_predictor();
    cps = CPS_RESET;
    foreach (mir[i]) mir[i] = '0;
    fcnt = 0; fstep = 0; scnt = 0;
    mon = 1; mvl = 7; mvr = 7; pan = 8'hFF;
    for (int c = 0; c < 4; c++) begin
      con[c] = 0; cd[c] = 0; len[c] = 0; loud[c] = 0;
    end
    for (int c = 0; c < 3; c++) begin
      per[c] = '0; env_inc[c] = 0; env_per[c] = 0; env_tim[c] = 0;
    end
    duty = '{0, 0}; dpos = '{0, 0};
    sw_per = 0; sw_neg = 0; sw_sh = 0; sw_tim = 0; sw_shadow = 0;
    wdac = 0; wpos = 0;
    lfsr = 32'h7FFF; nsh = 0; nw = 0; ndiv = 0;
  endfunction

  // ---------------- driver / monitor ----------------
  int tx_idle = 0, rx_stall = 0, hold_cycles = 0;
  logic taken = 1'b0;

  always @(negedge clk_i) begin
    bus_txn_t t;
    if (rst_ni && (!in_valid_i || taken)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
        t = pending_q.pop_front();
        in_valid_i <= 1'b1;
        opcode_i <= t.op;
        reg_offset_i <= t.off;
        write_data_i <= t.data;
      end else in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else out_ready_i <= rst_ni && ($urandom_range(99) >= rx_stall);
  end

  always @(posedge clk_i) begin
    sound_out_t e;
    bus_txn_t t;
    taken <= in_valid_i && in_ready_o;
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d l=%h r=%h d=%h", $time, result_kind_o,
                 left_sample_o, right_sample_o, read_data_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e.kind) n_reads++;
        else n_samples++;
        if (result_kind_o !== e.kind || left_sample_o !== e.left ||
            right_sample_o !== e.right || read_data_o !== e.data) begin
          $display("%0t: mismatch exp kind=%0d l=%h r=%h d=%h got kind=%0d l=%h r=%h d=%h",
                   $time, e.kind, e.left, e.right, e.data, result_kind_o, left_sample_o,
                   right_sample_o, read_data_o);
          errors++;
        end
      end
    end
    if (in_valid_i && in_ready_o) begin
      t.op = opcode_i;
      t.off = reg_offset_i;
      t.data = write_data_i;
      predict_sound(t);
      n_items++;
    end
  end

  // ---------------- stimulus ----------------
  task automatic push(logic [1:0] op, logic [5:0] off, logic [7:0] data);
    bus_txn_t t;
    t.op = op;
    t.off = off;
    t.data = data;
    pending_q.push_back(t);
  endtask

  task automatic push_ticks(int n);
    repeat (n) push(OP_TICK, 6'h00, 8'($urandom));
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_sample_period(logic [11:0] v);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = '0;
    pwdata = ($urandom & 32'hFFFF_F000) | v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    cps = v;
  endtask

  task automatic push_random(int n);
    int k;
    logic [5:0] off;
    logic [7:0] v;
    repeat (n) begin
      k = $urandom_range(99);
      off = $urandom_range(15, 63);
      if ($urandom_range(9) == 0) off = $urandom_range(0, 63);
      v = $urandom;
      if (off == REG_NR52 && $urandom_range(9) != 0) v[7] = 1'b1;
      if (k < 55) push(OP_TICK, 6'($urandom), v);
      else if (k < 85) push(OP_WRITE, off, v);
      else if (k < 97) push(OP_READ, off, v);
      else push(OP_UNUSED, 6'($urandom), v);
    end
  endtask

  initial begin
    reset_predictor();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_sample_period(12'd3);
    push(OP_WRITE, REG_NR52, 8'h80);
    push(OP_WRITE, REG_NR50, 8'h77);
    push(OP_WRITE, REG_NR51, 8'hFF);
    push(OP_WRITE, REG_NR12, 8'hF0);
    push(OP_WRITE, REG_NR11, 8'hC0);
    push(OP_WRITE, REG_NR13, 8'hFF);
    push(OP_WRITE, REG_NR14, 8'h87);
    push(OP_WRITE, REG_NR30, 8'h80);
    push(OP_WRITE, REG_NR32, 8'h20);
    push(OP_WRITE, REG_WAVE, 8'hAB);
    push(OP_WRITE, REG_NR34, 8'hC7);
    push(OP_WRITE, REG_NR42, 8'hF8);
    push(OP_WRITE, REG_NR43, 8'hFF);
    push(OP_WRITE, REG_NR44, 8'hC0);
    push_ticks(6);
    push(OP_READ, REG_NR52, 8'h00);
    push(OP_WRITE, 6'h05, 8'hFF);
    push(OP_READ, 6'h05, 8'h00);
    push(OP_READ, 6'h3F, 8'h00);
    push(OP_UNUSED, 6'h3F, 8'hFF);
    push(OP_WRITE, REG_NR52, 8'h00);
    push_ticks(3);
    push(OP_READ, REG_NR52, 8'h00);
    push(OP_WRITE, REG_NR52, 8'h80);
    wait_idle();

    tx_idle = 0; rx_stall = 0;
    set_sample_period(12'd1);
    push_random(280);
    hold_cycles = 300;
    wait_idle();

    tx_idle = 50; rx_stall = 0;
    set_sample_period(12'd0);
    push_random(280);
    wait_idle();

    tx_idle = 0; rx_stall = 50;
    set_sample_period(12'd7);
    push_random(280);
    wait_idle();

    tx_idle = 14; rx_stall = 14;
    set_sample_period(12'd95);
    push_random(280);
    wait_idle();

    // short tick bursts between sweep, length and envelope setups and retriggers
    tx_idle = 0; rx_stall = 0;
    set_sample_period(12'd5);
    push(OP_WRITE, REG_NR52, 8'h80);
    push(OP_WRITE, REG_NR10, 8'h11);
    push(OP_WRITE, REG_NR11, 8'h3E);
    push(OP_WRITE, REG_NR12, 8'h81);
    push(OP_WRITE, REG_NR13, 8'hF0);
    push(OP_WRITE, REG_NR14, 8'hC7);
    push(OP_WRITE, REG_NR21, 8'h7C);
    push(OP_WRITE, REG_NR22, 8'h19);
    push(OP_WRITE, REG_NR24, 8'hC2);
    push(OP_WRITE, REG_NR42, 8'hF1);
    push(OP_WRITE, REG_NR41, 8'h3D);
    push(OP_WRITE, REG_NR44, 8'hC0);
    for (int i = 0; i < 14; i++) begin
      push_ticks(6);
      push(OP_READ, REG_NR52, 8'h00);
      if (i % 3 == 0) begin
        push(OP_WRITE, REG_NR10, 8'($urandom));
        push(OP_WRITE, REG_NR14, 8'($urandom) | 8'h80);
        push(OP_WRITE, REG_NR22, 8'($urandom));
        push(OP_WRITE, REG_NR24, 8'($urandom) | 8'h80);
      end
    end
    wait_idle();

    $display("%0d transactions accepted, %0d samples and %0d reads checked", n_items,
             n_samples, n_reads);
    $display("covered: all registers, triggers, master on/off, sample periods 0..95, stalls");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
src/apu_pkg.sv
src/apu_mirror.sv
src/apu_mix.sv
src/apu_core.sv
src/four_channel_sound_generator.sv
src/apu_checker.sv
verif/four_channel_sound_generator_test.sv
